// ----- rtl/lwm_pkg.sv -----
package lwm_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [63:0] ALL_ONES     = '1;
  localparam logic [31:0] LINGER_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] snapshot_number;
    logic [63:0] thread_key;
    logic [30:0] job_key;
    logic [63:0] now_ticks;
  } lwm_in_t;

  typedef struct packed {
    logic [63:0] smallest_number;
    logic        add_dropped;
  } lwm_out_t;

  // Key and snapshot of one table slot, as held in the entry memory.
  typedef struct packed {
    logic [63:0] thread;
    logic [30:0] job;
    logic [63:0] snapshot;
  } lwm_entry_t;

  // Verdict of the compare unit on one slot.
  typedef struct packed {
    logic match;
    logic expired;
    logic less;
  } lwm_cmp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DELIVER
  } lwm_state_e;

endpackage

// ----- rtl/lwm_ram.sv -----
module lwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/lwm_scan_unit.sv -----
module lwm_scan_unit
  import lwm_pkg::*;
(
  input  lwm_entry_t  entry_i,
  input  logic [63:0] rm_time_i,
  input  logic        removed_i,
  input  lwm_in_t     item_i,
  input  logic [31:0] linger_i,
  input  logic [63:0] smallest_i,
  output lwm_cmp_t    cmp_o
);

  logic [64:0] age;

  // A borrow out of the age means the time lies before the stamp, so the
  // entry is not expired.
  always_comb begin
    age           = {1'b0, item_i.now_ticks} - {1'b0, rm_time_i};
    cmp_o.match   = (entry_i.thread == item_i.thread_key) && (entry_i.job == item_i.job_key);
    cmp_o.expired = removed_i && !age[64] && (age[63:0] >= {32'b0, linger_i});
    cmp_o.less    = entry_i.snapshot < smallest_i;
  end

endmodule

// ----- rtl/job_low_watermark_window.sv -----
// Low watermark window over a small table of in-flight jobs.
// An item on the input channel (in_valid_i / in_ready_o, payload in_item_i)
// is an add, a remove or a query. Every item yields exactly one item on the
// output channel (out_valid_o / out_ready_i, payload out_item_o): the
// smallest live snapshot for a query (all ones otherwise or when empty) and
// a flag that is set when an add of an absent key found the table full.
// Each item is handled by one sequential scan over the TABLE_ENTRIES slots.
// A shared compare unit looks at one slot per cycle, fed from the entry
// memories through their registered read port. After acceptance the block
// scans every slot, then commits its findings and then delivers the result.
// A new item is taken only in the idle step, which the block reaches once
// the last result has been loaded into the output register.
// The output register holds a finished result while the receiver stalls;
// the block waits in its deliver step until the register frees up.
// Reset empties the table at once through its per-slot valid bits and sets
// the linger time to 1000 ticks. cfg_we_i and cfg_wdata_i write the linger
// time in any cycle; it should be changed only while the block is idle.
module job_low_watermark_window
  import lwm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lwm_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lwm_out_t    out_item_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

  lwm_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  lwm_in_t item_q;
  logic [31:0] linger_q;
  logic [TABLE_ENTRIES-1:0] valid_q, removed_q;

  // Findings gathered during the scan.
  logic             match_q, free_q, dropped_q;
  logic [IDX_W-1:0] match_idx_q, free_idx_q;
  logic [63:0]      smallest_q;

  lwm_out_t out_q;
  logic     out_valid_q;

  // Control from the sequencer.
  logic             accept, eval_en, commit_en, load_out;
  logic             key_we, time_we, drop;
  logic [IDX_W-1:0] rd_addr, ev_idx;

  lwm_entry_t entry_wr, entry_rd;
  logic [63:0] time_rd;
  lwm_cmp_t   cmp;

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    eval_en    = 1'b0;
    commit_en  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_SCAN:    eval_en    = (cnt_q != '0);
      ST_COMMIT:  commit_en  = 1'b1;
      ST_DELIVER: load_out   = !out_valid_q || out_ready_i;
      default:    in_ready_o = 1'b0;
    endcase
  end

  assign accept  = in_valid_i && in_ready_o;
  assign rd_addr = cnt_q[IDX_W-1:0];
  // The memories answer through a registered read port, so the slot under
  // evaluation is the one addressed in the previous cycle.
  assign ev_idx  = IDX_W'(cnt_q - CNT_W'(1));

  assign key_we  = commit_en && (item_q.kind == KIND_ADD) && !match_q && free_q;
  assign drop    = commit_en && (item_q.kind == KIND_ADD) && !match_q && !free_q;
  assign time_we = commit_en && (item_q.kind == KIND_REMOVE) && match_q;

  assign entry_wr.thread   = item_q.thread_key;
  assign entry_wr.job      = item_q.job_key;
  assign entry_wr.snapshot = item_q.snapshot_number;

  lwm_ram #(
    .WIDTH ($bits(lwm_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_idx_q),
    .wdata_i (entry_wr),
    .raddr_i (rd_addr),
    .rdata_o (entry_rd)
  );

  lwm_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_ENTRIES)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (match_idx_q),
    .wdata_i (item_q.now_ticks),
    .raddr_i (rd_addr),
    .rdata_o (time_rd)
  );

  lwm_scan_unit u_scan (
    .entry_i    (entry_rd),
    .rm_time_i  (time_rd),
    .removed_i  (removed_q[ev_idx]),
    .item_i     (item_q),
    .linger_i   (linger_q),
    .smallest_i (smallest_q),
    .cmp_o      (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      linger_q    <= LINGER_RESET;
      valid_q     <= '0;
      removed_q   <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;

      if (cfg_we_i) begin
        linger_q <= cfg_wdata_i;
      end

      if (accept) begin
        match_q    <= 1'b0;
        free_q     <= 1'b0;
        dropped_q  <= 1'b0;
        smallest_q <= ALL_ONES;
      end

      if (eval_en) begin
        if (valid_q[ev_idx]) begin
          if ((item_q.kind == KIND_ADD || item_q.kind == KIND_REMOVE) &&
              cmp.match && !match_q) begin
            match_q     <= 1'b1;
            match_idx_q <= ev_idx;
          end
          if (item_q.kind == KIND_QUERY) begin
            if (cmp.expired) begin
              valid_q[ev_idx]   <= 1'b0;
              removed_q[ev_idx] <= 1'b0;
            end else if (cmp.less) begin
              smallest_q <= entry_rd.snapshot;
            end
          end
        end else if (!free_q) begin
          // The lowest free slot is the first empty one the scan meets.
          free_q     <= 1'b1;
          free_idx_q <= ev_idx;
        end
      end

      if (key_we) begin
        valid_q[free_idx_q]   <= 1'b1;
        removed_q[free_idx_q] <= 1'b0;
      end
      if (time_we) begin
        removed_q[match_idx_q] <= 1'b1;
      end
      if (drop) begin
        dropped_q <= 1'b1;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (load_out) begin
      out_q.smallest_number <= smallest_q;
      out_q.add_dropped     <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_drop_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |-> (&valid_q))
    else $error("add dropped although a slot was free");

  a_insert_sets_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |=> (valid_q[$past(free_idx_q)] && !removed_q[$past(free_idx_q)]))
    else $error("inserted slot not live after commit");

  a_drop_no_minimum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.add_dropped) |-> (out_item_o.smallest_number == ALL_ONES))
    else $error("dropped add carries a minimum");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= CNT_LAST))
    else $error("scan counter ran past the table");
`endif

endmodule

// ----- test/job_low_watermark_window_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the job low watermark window.
//
// A queue of pending job events is filled by the stimulus process. A clocked
// driver feeds them to the block over the valid/ready input channel. Each time
// an item is accepted, the driver runs it through a local model of the job
// table, and that model's answer goes into a queue of expected results. A
// clocked monitor takes results off the output channel and compares each one,
// field by field, with the oldest expected result.
//
// Both sides go idle in random bursts. The linger time is rewritten only
// between phases, once every expected result has come back.
module job_low_watermark_window_tb;
  import lwm_pkg::*;

  localparam int SLOTS = 16;
  localparam int KEY_POOL = 20;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 265;
  // This tail gives a stray result time to show up before the run ends.
  localparam int SETTLE_CYCLES = 30;
  localparam int PRINT_LIMIT = 40;

  // The package names the three real kinds. The fourth code is legal on the
  // wire, and the block has to answer it without touching the table.
  localparam logic [1:0] KIND_IDLE_CODE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  lwm_in_t     in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  lwm_out_t    out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  job_low_watermark_window #(
    .TABLE_ENTRIES(SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Local copy of the job table and of the linger register.
  logic        tbl_valid   [SLOTS];
  logic        tbl_removed [SLOTS];
  logic [63:0] tbl_stamp   [SLOTS];
  logic [63:0] tbl_snap    [SLOTS];
  logic [63:0] tbl_thread  [SLOTS];
  logic [30:0] tbl_job     [SLOTS];
  logic [31:0] linger_cur;

  lwm_in_t  pending_jobs[$];
  lwm_out_t watermark_due[$];
  int       results_owed = 0;
  int       mismatches = 0;

  // Idle behavior. The percentages are set per phase by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int          send_gap = 0;
  int          take_stall = 0;

  // Keys that random traffic draws from. There are a few more of them than
  // the table has slots, so the table fills up now and then.
  logic [63:0] pool_thread[KEY_POOL];
  logic [30:0] pool_job[KEY_POOL];
  logic [63:0] sim_now;
  int unsigned tick_scale;

  // Applies one item to the local table and returns the result the block
  // must produce for it.
  function automatic lwm_out_t predict_watermark(lwm_in_t item);
    lwm_out_t res;
    int       hit;
    int       free_slot;
    res.smallest_number = ALL_ONES;
    res.add_dropped = 1'b0;
    hit = -1;
    free_slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (hit < 0 && tbl_valid[s] && tbl_thread[s] == item.thread_key &&
          tbl_job[s] == item.job_key) begin
        hit = s;
      end
      if (free_slot < 0 && !tbl_valid[s]) begin
        free_slot = s;
      end
    end
    case (item.kind)
      KIND_ADD: begin
        // A present key keeps its entry, even one already marked removed.
        if (hit < 0) begin
          if (free_slot < 0) begin
            res.add_dropped = 1'b1;
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_removed[free_slot] = 1'b0;
            tbl_stamp[free_slot] = '0;
            tbl_snap[free_slot] = item.snapshot_number;
            tbl_thread[free_slot] = item.thread_key;
            tbl_job[free_slot] = item.job_key;
          end
        end
      end
      KIND_REMOVE: begin
        // A second remove simply moves the stamp.
        if (hit >= 0) begin
          tbl_removed[hit] = 1'b1;
          tbl_stamp[hit] = item.now_ticks;
        end
      end
      KIND_QUERY: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_valid[s]) begin
            // A time earlier than the stamp never counts as expired.
            if (tbl_removed[s] && item.now_ticks >= tbl_stamp[s] &&
                item.now_ticks - tbl_stamp[s] >= {32'd0, linger_cur}) begin
              tbl_valid[s] = 1'b0;
              tbl_removed[s] = 1'b0;
            end else if (tbl_snap[s] < res.smallest_number) begin
              res.smallest_number = tbl_snap[s];
            end
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic lwm_in_t job_event(logic [1:0] kind, logic [63:0] snap,
                                        logic [63:0] thread, logic [30:0] job,
                                        logic [63:0] now);
    lwm_in_t it;
    it.kind = kind;
    it.snapshot_number = snap;
    it.thread_key = thread;
    it.job_key = job;
    it.now_ticks = now;
    return it;
  endfunction

  task automatic post_job(input lwm_in_t it);
    pending_jobs.push_back(it);
    results_owed++;
  endtask

  // Most random traffic is well formed: adds, removes and queries on a small
  // set of keys, with a clock that mostly moves forward in steps sized to
  // the linger time. The rest is noise: arbitrary keys and kinds, and times
  // that jump anywhere.
  function automatic lwm_in_t next_job_event();
    lwm_in_t     it;
    int unsigned pick;
    int unsigned k;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, KEY_POOL - 1);
    it.thread_key = pool_thread[k];
    it.job_key = pool_job[k];
    case ($urandom_range(0, 19))
      0: it.snapshot_number = '0;
      1: it.snapshot_number = ALL_ONES;
      2, 3, 4, 5, 6, 7, 8, 9: it.snapshot_number = {32'd0, $urandom};
      default: it.snapshot_number = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 9) == 0) begin
      it.now_ticks = {$urandom, $urandom};
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        sim_now = sim_now - $urandom_range(0, tick_scale);
      end else begin
        sim_now = sim_now + $urandom_range(0, tick_scale);
      end
      it.now_ticks = sim_now;
    end
    if (pick < 35) begin
      it.kind = KIND_ADD;
    end else if (pick < 65) begin
      it.kind = KIND_REMOVE;
    end else if (pick < 92) begin
      it.kind = KIND_QUERY;
    end else if (pick < 95) begin
      it.kind = KIND_IDLE_CODE;
    end else begin
      raw = $urandom;
      it.kind = raw[1:0];
      it.thread_key = {$urandom, $urandom};
      raw = $urandom;
      it.job_key = raw[30:0];
    end
    return it;
  endfunction

  // The register is only written with the block idle, so the local copy can
  // follow right away.
  task automatic set_linger(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    linger_cur = value;
  endtask

  task automatic wait_idle();
    while (results_owed != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Driver. It moves to the next pending item only once the current one is
  // accepted, and it may first hold valid low for a random burst of cycles.
  always @(posedge clk_i) begin : feed_jobs
    logic holding;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      holding = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        watermark_due.push_back(predict_watermark(in_item_i));
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_jobs.size() != 0 &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 15) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_jobs.size() != 0) begin
          in_item_i <= pending_jobs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. It checks every accepted result against the oldest expected
  // one, and it stalls the output channel in random bursts.
  always @(posedge clk_i) begin : check_results
    lwm_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (watermark_due.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_item_o));
        end else begin
          want = watermark_due.pop_front();
          results_owed--;
          if (out_item_o.smallest_number !== want.smallest_number) begin
            report_mismatch($sformatf("smallest_number %h, expected %h",
                                      out_item_o.smallest_number, want.smallest_number));
          end
          if (out_item_o.add_dropped !== want.add_dropped) begin
            report_mismatch($sformatf("add_dropped %b, expected %b",
                                      out_item_o.add_dropped, want.add_dropped));
          end
        end
      end
      if (take_stall != 0) begin
        take_stall--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < take_idle_pct) begin
        take_stall = $urandom_range(1, 15) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // The limit lies well beyond the time the slowest correct run takes.
  initial begin
    #2_000_000;
    $display("job_low_watermark_window verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] phase_linger[PHASES];
    int unsigned phase_send[PHASES];
    int unsigned phase_take[PHASES];
    logic [31:0] raw;

    phase_linger = '{32'd0, 32'hFFFF_FFFF, 32'd37, 32'd1000, 32'd3, 32'd250};
    phase_send = '{20, 0, 35, 10, 25, 0};
    phase_take = '{25, 30, 0, 40, 10, 0};

    for (int s = 0; s < SLOTS; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_removed[s] = 1'b0;
      tbl_stamp[s] = '0;
      tbl_snap[s] = '0;
      tbl_thread[s] = '0;
      tbl_job[s] = '0;
    end
    linger_cur = LINGER_RESET;

    pool_thread[0] = '0;
    pool_job[0] = '0;
    pool_thread[1] = ALL_ONES;
    pool_job[1] = '1;
    for (int k = 2; k < KEY_POOL; k++) begin
      raw = $urandom;
      pool_thread[k] = {$urandom, $urandom};
      pool_job[k] = raw[30:0];
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the linger time still at its reset value of 1000.
    send_idle_pct = 15;
    take_idle_pct = 15;
    // A query on the empty table returns all ones.
    post_job(job_event(KIND_QUERY, '0, '0, '0, 64'd0));
    post_job(job_event(KIND_ADD, ALL_ONES, pool_thread[0], pool_job[0], '0));
    post_job(job_event(KIND_ADD, '0, pool_thread[1], pool_job[1], ALL_ONES));
    // Remove twice. The second stamp replaces the first.
    post_job(job_event(KIND_REMOVE, ALL_ONES, pool_thread[1], pool_job[1], 64'd100));
    post_job(job_event(KIND_REMOVE, '0, pool_thread[1], pool_job[1], 64'd500));
    // An add of a key that is present but removed keeps the old entry.
    post_job(job_event(KIND_ADD, 64'd7, pool_thread[1], pool_job[1], '0));
    // One tick short of the linger time, the entry still counts.
    post_job(job_event(KIND_QUERY, '0, '0, '0, 64'd1499));
    // A time before the stamp does not expire the entry.
    post_job(job_event(KIND_QUERY, '0, '0, '0, 64'd50));
    // Now it expires, and only the all-ones snapshot is left.
    post_job(job_event(KIND_QUERY, '0, '0, '0, 64'd1500));
    // A remove of an absent key changes nothing.
    post_job(job_event(KIND_REMOVE, '0, pool_thread[19], pool_job[19], 64'd1600));
    // The unused kind has no effect on the table.
    post_job(job_event(KIND_IDLE_CODE, ALL_ONES, ALL_ONES, '1, ALL_ONES));
    // Fill every slot, then try one add too many.
    for (int k = 2; k < 17; k++) begin
      post_job(job_event(KIND_ADD, {$urandom, $urandom}, pool_thread[k], pool_job[k],
                         64'd1700));
    end
    post_job(job_event(KIND_ADD, 64'd1, pool_thread[19], pool_job[19], 64'd1700));
    post_job(job_event(KIND_QUERY, '0, '0, '0, ALL_ONES));
    wait_idle();

    // Random phases, each under its own linger time. The extremes come early
    // and the last phase runs with no idling on either side.
    sim_now = 64'd2000;
    for (int p = 0; p < PHASES; p++) begin
      set_linger(phase_linger[p]);
      tick_scale = phase_linger[p] / 8 + 1;
      send_idle_pct = phase_send[p];
      take_idle_pct = phase_take[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        post_job(next_job_event());
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("job_low_watermark_window verification clean");
    end else begin
      $display("job_low_watermark_window verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lwm_pkg.sv
rtl/lwm_ram.sv
rtl/lwm_scan_unit.sv
rtl/job_low_watermark_window.sv
test/job_low_watermark_window_tb.sv
